// ===== sv/mfcc_pkg.sv =====
// Shared types, constants and functions for the measurement frame CRC checker.
// Used by mfcc_frame and measurement_frame_crc_checker_top; no dependencies.
`default_nettype none

package mfcc_pkg;

  // Frame geometry and check byte parameters.
  localparam int unsigned FRAME_BYTES = 18;
  localparam int unsigned POS_W       = 5;
  localparam int unsigned WORD_COUNT  = 3;
  localparam int unsigned WORD_IDX_W  = 2;
  localparam logic [7:0]  CHECK_INIT  = 8'hFF;
  localparam logic [7:0]  CHECK_POLY  = 8'h31;
  localparam logic [7:0]  CHECK_TOP   = 8'h80;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

  // Frame status codes.
  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_CHECK_FAIL = 2'd1,
    STATUS_ZERO_WORD  = 2'd2
  } status_t;

  // Role of one byte position within the frame.
  typedef struct packed {
    logic                  is_check;
    logic [WORD_IDX_W-1:0] word_idx;
  } byte_role_t;

  // One finished frame.
  typedef struct packed {
    status_t     status;
    logic [31:0] humidity_bits;
    logic [31:0] temperature_bits;
    logic [31:0] co2_bits;
  } frame_result_t;

  // CRC-8, MSB first, one byte folded in.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if ((c & CHECK_TOP) != 8'h00) begin
        c = {c[6:0], 1'b0} ^ CHECK_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Every third byte is a check byte; every six bytes start a new word.
  function automatic byte_role_t pos_role(input logic [POS_W-1:0] p);
    byte_role_t r;
    r.is_check = (p == 5'd2) || (p == 5'd5) || (p == 5'd8) ||
                 (p == 5'd11) || (p == 5'd14) || (p == 5'd17);
    if (p < 5'd6) begin
      r.word_idx = 2'd0;
    end else if (p < 5'd12) begin
      r.word_idx = 2'd1;
    end else begin
      r.word_idx = 2'd2;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/mfcc_frame.sv =====
// Frame state of the checker: byte position, running CRC, word assembly, status.
// Depends on mfcc_pkg.
`default_nettype none

module mfcc_frame (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   step,        // consume the presented byte
  input  wire logic [7:0]             rx_byte,
  input  wire logic                   frame_start,
  output logic                        res_last,    // presented byte closes the frame
  output mfcc_pkg::frame_result_t     res
);

  logic [mfcc_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]                 crc_r, crc_nxt;
  logic                       fail_r, fail_nxt;
  logic [31:0]                words_r   [mfcc_pkg::WORD_COUNT];
  logic [31:0]                words_nxt [mfcc_pkg::WORD_COUNT];

  logic                       start;
  logic [mfcc_pkg::POS_W-1:0] pos;
  logic [7:0]                 crc_cur;
  logic                       fail_cur;
  mfcc_pkg::byte_role_t       role;
  logic                       any_zero;

  // Effective state for this byte after a possible resynchronization.
  always_comb begin
    start    = frame_start || (pos_r > mfcc_pkg::LAST_POS);
    pos      = start ? '0 : pos_r;
    crc_cur  = start ? mfcc_pkg::CHECK_INIT : crc_r;
    fail_cur = start ? 1'b0 : fail_r;
    role     = mfcc_pkg::pos_role(pos);
    res_last = (pos == mfcc_pkg::LAST_POS);
  end

  // Data bytes feed the CRC and the word; check bytes compare and restart the CRC.
  always_comb begin
    crc_nxt  = crc_cur;
    fail_nxt = fail_cur;
    for (int w = 0; w < mfcc_pkg::WORD_COUNT; w++) begin
      words_nxt[w] = words_r[w];
    end
    if (!role.is_check) begin
      crc_nxt = mfcc_pkg::crc8_update(crc_cur, rx_byte);
      for (int w = 0; w < mfcc_pkg::WORD_COUNT; w++) begin
        if (role.word_idx == mfcc_pkg::WORD_IDX_W'(w)) begin
          words_nxt[w] = {words_r[w][23:0], rx_byte};
        end
      end
    end else begin
      fail_nxt = fail_cur || (rx_byte != crc_cur);
      crc_nxt  = mfcc_pkg::CHECK_INIT;
    end
    pos_nxt = pos + 5'd1;
    if (res_last) begin
      pos_nxt  = '0;
      crc_nxt  = mfcc_pkg::CHECK_INIT;
    end
  end

  // Result as it stands once this byte is folded in.
  always_comb begin
    any_zero             = (words_nxt[0] == 32'd0) || (words_nxt[1] == 32'd0) ||
                           (words_nxt[2] == 32'd0);
    res.co2_bits         = words_nxt[0];
    res.temperature_bits = words_nxt[1];
    res.humidity_bits    = words_nxt[2];
    if (fail_nxt) begin
      res.status = mfcc_pkg::STATUS_CHECK_FAIL;
    end else if (any_zero) begin
      res.status = mfcc_pkg::STATUS_ZERO_WORD;
    end else begin
      res.status = mfcc_pkg::STATUS_OK;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      crc_r  <= mfcc_pkg::CHECK_INIT;
      fail_r <= 1'b0;
    end else if (step) begin
      pos_r  <= pos_nxt;
      crc_r  <= crc_nxt;
      fail_r <= res_last ? 1'b0 : fail_nxt;
    end
  end

  // Word assembly registers.
  always_ff @(posedge clk) begin
    if (step) begin
      for (int w = 0; w < mfcc_pkg::WORD_COUNT; w++) begin
        words_r[w] <= words_nxt[w];
      end
    end
  end

  // The position never leaves the frame.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= mfcc_pkg::LAST_POS)
    else $error("byte position out of frame");

  // A completed frame always restarts the CRC and failure flag.
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res_last) |=> (pos_r == '0) && (crc_r == mfcc_pkg::CHECK_INIT) && !fail_r)
    else $error("frame state not restarted after last byte");

  // After a check byte the CRC register holds its initial value.
  a_check_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (step && role.is_check) |=> (crc_r == mfcc_pkg::CHECK_INIT))
    else $error("CRC not restarted after check byte");

endmodule

`default_nettype wire

// ===== sv/measurement_frame_crc_checker_top.sv =====
// Top level of the measurement frame CRC checker: input register, frame logic, result register.
// Depends on mfcc_pkg and mfcc_frame.
`default_nettype none

// Takes the 18 bytes of a sensor measurement response, one byte per request on the
// in_ stream, checks each group's CRC-8 (poly 0x31, init 0xFF) and, on the last byte,
// issues one request on the out_ stream with the three raw 32-bit words and a status
// (0 ok, 1 check mismatch, 2 a zero word). One byte is taken per clock cycle while the input
// is not stalled: each byte is held in the input register and its result, if any, is loaded
// from there into the output register; the only stall is a frame's last byte waiting while
// the previous result is still held and not taken. in_tuser high marks the first byte of a
// frame and drops any partial frame.
module measurement_frame_crc_checker_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] rx_byte
  input  wire logic         in_tuser,   // [0] frame_start
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [103:0]      out_tdata   // [31:0] co2_bits, [63:32] temperature_bits,
                                        // [95:64] humidity_bits, [97:96] frame_status, zero pad
);

  logic                    in_valid_r;
  logic [7:0]              in_byte_r;
  logic                    in_start_r;
  logic                    out_valid_r;
  mfcc_pkg::frame_result_t out_res_r;
  logic                    advance;
  logic                    res_last;
  mfcc_pkg::frame_result_t res;

  mfcc_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .rx_byte     (in_byte_r),
    .frame_start (in_start_r),
    .res_last    (res_last),
    .res         (res)
  );

  // The held byte moves on unless it closes a frame and the result slot is full.
  always_comb begin
    advance   = in_valid_r && (!res_last || !out_valid_r || out_tready);
    in_tready = !in_valid_r || advance;
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r  <= in_tdata;
      in_start_r <= in_tuser;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res_last) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_last) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r};

  // A result is loaded only when the slot is free or being emptied.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_last) |-> (!out_valid_r || out_tready))
    else $error("result overwritten before it was taken");

  // A new result request comes only from a frame's last byte.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(advance && res_last))
    else $error("result appeared without a closing byte");

  // Back pressure on the input only while a byte is held.
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_valid_r && res_last && out_valid_r && !out_tready))
    else $error("input stalled without cause");

endmodule

`default_nettype wire

// ===== verif/tb_measurement_frame_crc_checker_top.sv =====
// Testbench for measurement_frame_crc_checker_top. It streams response bytes with random gaps,
// predicts each frame result in a small scoreboard class and compares the results field by field.
// Depends on mfcc_pkg and the checker RTL only.

module tb_measurement_frame_crc_checker_top;

  localparam int unsigned ITEM_TARGET     = 1950;
  localparam int unsigned CYCLE_LIMIT     = 600000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned HOLD_OFF_AFTER  = 20;
  localparam int unsigned DRAIN_CYCLES    = 20;
  localparam int unsigned MAX_REPORTS     = 40;

  // Tracks the frame position, group CRC and word assembly, and keeps the frame results
  // that are still due from the block.
  class frame_scoreboard;
    logic [mfcc_pkg::POS_W-1:0] position;
    logic [7:0]                 group_crc;
    logic [31:0]                words [mfcc_pkg::WORD_COUNT];
    bit                         mismatch_seen;
    mfcc_pkg::frame_result_t    pending_frames [$];
    int unsigned                errors;
    int unsigned                results_seen;

    function new();
      errors = 0;
      results_seen = 0;
      for (int i = 0; i < mfcc_pkg::WORD_COUNT; i++) begin
        words[i] = 32'h0;
      end
      restart();
    endfunction

    // CRC-8 over one byte, MSB first.
    static function logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      repeat (8) begin
        c = c[7] ? ({c[6:0], 1'b0} ^ mfcc_pkg::CHECK_POLY) : {c[6:0], 1'b0};
      end
      return c;
    endfunction

    function void restart();
      position = '0;
      group_crc = mfcc_pkg::CHECK_INIT;
      mismatch_seen = 1'b0;
    endfunction

    // Called for every accepted request on the byte stream.
    function void note_byte(input logic [7:0] b, input logic fs);
      int unsigned             p;
      mfcc_pkg::frame_result_t res;
      if (fs || position >= mfcc_pkg::FRAME_BYTES) begin
        restart();
      end
      p = position;
      // Two data bytes feed the CRC and the word, the third byte is the check byte.
      if (p % 3 != 2) begin
        group_crc = crc8_step(group_crc, b);
        words[p / 6] = {words[p / 6][23:0], b};
      end else begin
        if (b != group_crc) begin
          mismatch_seen = 1'b1;
        end
        group_crc = mfcc_pkg::CHECK_INIT;
      end
      if (p + 1 < mfcc_pkg::FRAME_BYTES) begin
        position = mfcc_pkg::POS_W'(p + 1);
      end else begin
        res.co2_bits = words[0];
        res.temperature_bits = words[1];
        res.humidity_bits = words[2];
        // A check mismatch wins over a zero word.
        if (mismatch_seen) begin
          res.status = mfcc_pkg::STATUS_CHECK_FAIL;
        end else if (words[0] == 0 || words[1] == 0 || words[2] == 0) begin
          res.status = mfcc_pkg::STATUS_ZERO_WORD;
        end else begin
          res.status = mfcc_pkg::STATUS_OK;
        end
        pending_frames.push_back(res);
        restart();
      end
    endfunction

    function void compare_field(input string name, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
        end
      end
    endfunction

    // Called for every accepted request on the result stream.
    function void check_result(input logic [103:0] data);
      mfcc_pkg::frame_result_t exp_r;
      results_seen++;
      if (pending_frames.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: unexpected frame result, expected none, got %h", $time, data);
        end
        return;
      end
      exp_r = pending_frames.pop_front();
      compare_field("co2_bits", exp_r.co2_bits, data[31:0]);
      compare_field("temperature_bits", exp_r.temperature_bits, data[63:32]);
      compare_field("humidity_bits", exp_r.humidity_bits, data[95:64]);
      compare_field("frame_status", 32'(exp_r.status), 32'(data[97:96]));
    endfunction
  endclass

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_tvalid = 1'b0;
  logic           in_tready;
  logic [7:0]     in_tdata = 8'h00;
  logic           in_tuser = 1'b0;
  logic           out_tvalid;
  logic           out_tready = 1'b0;
  logic [103:0]   out_tdata;

  frame_scoreboard sb;
  int unsigned     cycle_count = 0;
  int unsigned     bytes_sent = 0;
  bit              send_burst = 1'b0;

  always #6 clk = ~clk;

  measurement_frame_crc_checker_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: checks each accepted result and stalls at random, with one long hold-off.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned r;
    bit          ready_burst;
    bit          hold_done;
    stall_left = 0;
    ready_burst = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        sb.check_result(out_tdata);
      end
      if (!hold_done && sb.results_seen >= HOLD_OFF_AFTER) begin
        hold_done = 1'b1;
        stall_left = HOLD_OFF_CYCLES;
      end
      if ($urandom_range(0, 63) == 0) begin
        ready_burst = !ready_burst;
      end
      r = $urandom_range(0, 99);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (ready_burst || r < 65) begin
        out_tready <= 1'b1;
      end else if (r < 97) begin
        out_tready <= 1'b0;
      end else begin
        stall_left = $urandom_range(8, 40);
        out_tready <= 1'b0;
      end
    end
  end

  // Offers one byte after a random gap and waits for the request to be taken.
  task automatic send_byte(input logic [7:0] b, input logic fs);
    int unsigned gap;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (send_burst || r < 60) begin
      gap = 0;
    end else if (r < 93) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 30);
    end
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= fs;
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    sb.note_byte(b, fs);
    bytes_sent++;
  endtask

  // Sends the first len bytes of a frame built from three words; groups flagged in
  // bad_groups get a corrupted check byte.
  task automatic send_frame(input logic [2:0][31:0] w, input logic fs,
                            input logic [5:0] bad_groups, input int unsigned len);
    logic [7:0] frame_bytes [mfcc_pkg::FRAME_BYTES];
    logic [7:0] hi;
    logic [7:0] lo;
    for (int g = 0; g < 6; g++) begin
      hi = (g % 2 == 0) ? w[g / 2][31:24] : w[g / 2][15:8];
      lo = (g % 2 == 0) ? w[g / 2][23:16] : w[g / 2][7:0];
      frame_bytes[3 * g] = hi;
      frame_bytes[3 * g + 1] = lo;
      frame_bytes[3 * g + 2] = frame_scoreboard::crc8_step(
        frame_scoreboard::crc8_step(mfcc_pkg::CHECK_INIT, hi), lo);
      if (bad_groups[g]) begin
        frame_bytes[3 * g + 2] ^= 8'($urandom_range(1, 255));
      end
    end
    for (int k = 0; k < len; k++) begin
      send_byte(frame_bytes[k], (k == 0) ? fs : 1'b0);
    end
  endtask

  // Mostly random words, with zero and all-ones words now and then.
  function automatic logic [31:0] random_word();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 2) begin
      return 32'h0;
    end else if (r == 2) begin
      return 32'hFFFF_FFFF;
    end
    return $urandom;
  endfunction

  initial begin : stimulus
    logic [2:0][31:0] w;
    int unsigned      r;
    bit               drained;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A partial frame dropped by a new frame start, then a frame with a zero word and
    // a bad check byte, where the check failure must win.
    w = {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    send_frame(w, 1'b1, 6'b000000, 4);
    w = {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000};
    send_frame(w, 1'b1, 6'b000010, mfcc_pkg::FRAME_BYTES);

    // Random frames: mostly well formed, plus truncated frames, noise and bad checks.
    drained = 1'b0;
    while (bytes_sent < ITEM_TARGET) begin
      if (!drained && bytes_sent >= ITEM_TARGET / 2) begin
        drained = 1'b1;
        in_tvalid <= 1'b0;
        do begin
          @(posedge clk);
        end while (sb.pending_frames.size() != 0);
      end
      if ($urandom_range(0, 7) == 0) begin
        send_burst = !send_burst;
      end
      w = {random_word(), random_word(), random_word()};
      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_frame(w, 1'($urandom_range(0, 3) != 0),
                   ($urandom_range(0, 4) == 0) ? 6'(1 << $urandom_range(0, 5)) : 6'd0,
                   mfcc_pkg::FRAME_BYTES);
      end else if (r < 80) begin
        send_frame(w, 1'b1, 6'd0, $urandom_range(1, mfcc_pkg::FRAME_BYTES - 1));
      end else if (r < 90) begin
        repeat ($urandom_range(1, 10)) begin
          send_byte(8'($urandom), 1'($urandom_range(0, 1)));
        end
      end else begin
        send_frame(w, 1'b0, 6'($urandom), mfcc_pkg::FRAME_BYTES);
      end
    end

    // Let every outstanding result arrive, then allow for the pipeline latency.
    in_tvalid <= 1'b0;
    do begin
      @(posedge clk);
    end while (sb.pending_frames.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_frames.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
